// File: hw/rtl/csi_pkg.sv
// Shared constants, widths and state type for the constant-speed setpoint interpolator.
// No dependencies; every other file refers to it by scoped names.
package csi_pkg;

    localparam int POS_FRAC_BITS = 12;

    localparam int POS_W   = 16;
    localparam int DELTA_W = 17;
    localparam int SPEED_W = 16;
    localparam int STEP_W  = 20;
    localparam int TIME_W  = 32;
    localparam int SQ_W    = 36;              // sum of three squares, even for 2-bit digits
    localparam int ROOT_W  = SQ_W / 2;
    localparam int ROOT_CNT_W = 5;
    localparam int DIV_NW  = 49;              // |delta| * elapsed, and len * scale
    localparam int DIV_DW  = 36;              // speed << POS_FRAC_BITS, and duration
    localparam int DIV_CNT_W = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    // 2^8 speed fraction times microseconds per second
    localparam logic [27:0] US_SCALE = 28'd256000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP_US = 8'd1;

    localparam logic [SPEED_W-1:0] MOVE_SPEED_RST = 16'd256;
    localparam logic [STEP_W-1:0]  TICK_STEP_RST  = 20'd10000;

    localparam logic KIND_TARGET = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_SCALE,
        ST_DGO,
        ST_DDIV,
        ST_TSTEP,
        ST_TMUL,
        ST_TGO,
        ST_TDIV,
        ST_OUT
    } t_state;

endpackage

// File: hw/rtl/csi_channels.sv
// Handshake channels of the interpolator: target/tick items, position results, config writes.
// Depends on csi_pkg for field widths.
interface csi_item_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [csi_pkg::POS_W-1:0]  target_x;
    logic signed [csi_pkg::POS_W-1:0]  target_y;
    logic signed [csi_pkg::POS_W-1:0]  target_z;
    modport source (output valid, kind, target_x, target_y, target_z, input ready);
    modport sink   (input valid, kind, target_x, target_y, target_z, output ready);
endinterface

interface csi_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [csi_pkg::POS_W-1:0]  pos_x;
    logic signed [csi_pkg::POS_W-1:0]  pos_y;
    logic signed [csi_pkg::POS_W-1:0]  pos_z;
    logic                              moving;
    modport source (output valid, pos_x, pos_y, pos_z, moving, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, moving, output ready);
endinterface

interface csi_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [csi_pkg::CFG_IDX_W-1:0]       index;
    logic [csi_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/csi_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by duration and position math.
// Depends on csi_pkg for operand widths.
module csi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [csi_pkg::DIV_NW-1:0]    i_num,
    input  logic [csi_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_done,
    output logic [csi_pkg::DIV_NW-1:0]    o_quo
);
    logic [csi_pkg::DIV_NW-1:0]    r_num;
    logic [csi_pkg::DIV_DW-1:0]    r_rem;
    logic [csi_pkg::DIV_DW-1:0]    r_den;
    logic [csi_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [csi_pkg::DIV_DW:0] rem_sh;
    logic                     ge;
    logic [csi_pkg::DIV_DW:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[csi_pkg::DIV_NW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= csi_pkg::DIV_CNT_W'(csi_pkg::DIV_NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[csi_pkg::DIV_NW-2:0], ge};
                r_rem <= n_rem[csi_pkg::DIV_DW-1:0];   // remainder stays below divisor
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == csi_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// File: hw/rtl/constant_speed_setpoint_interpolator_top.sv
// Constant-speed 3-axis setpoint interpolator, top level with sequencer and datapath.
// Depends on csi_pkg, csi_channels and csi_div.
//
//   port       dir   handshake        payload
//   i_item     in    valid/ready      kind, target_x, target_y, target_z
//   o_result   out   valid/ready      pos_x, pos_y, pos_z, moving
//   i_cfg      in    valid/ready      index, data (0 move_speed, 1 tick_step_us)
//
// One item at a time. A target item runs 3 squarings, 18 square-root steps (one per two-bit
// radicand digit, one root bit each) and one pass of the serial divider, which a zero-length
// move skips. A tick while moving runs one serial division per axis; an idle tick runs none.
// Synchronous active-low reset. The result sits in an output register; the next item
// is taken while it waits, and a second result holds the sequencer until it drains.
module constant_speed_setpoint_interpolator_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csi_item_if.sink              i_item,
    csi_result_if.source          o_result,
    csi_cfg_if.sink               i_cfg
);
    localparam int PW = csi_pkg::POS_W;
    localparam int DW = csi_pkg::DELTA_W;

    csi_pkg::t_state r_state, n_state;

    logic [csi_pkg::SPEED_W-1:0] r_speed;
    logic [csi_pkg::STEP_W-1:0]  r_step;

    logic signed [PW-1:0] r_cur   [3];
    logic signed [PW-1:0] r_start [3];
    logic signed [DW-1:0] r_delta [3];
    logic [csi_pkg::TIME_W-1:0] r_elapsed;
    logic [csi_pkg::TIME_W-1:0] r_dur;

    logic [1:0]                      r_ax;
    logic [csi_pkg::SQ_W-1:0]        r_acc;
    logic [csi_pkg::ROOT_W-1:0]      r_root;
    logic [csi_pkg::ROOT_W:0]        r_rem;
    logic [csi_pkg::ROOT_CNT_W-1:0]  r_cnt;
    logic [csi_pkg::DIV_NW-1:0]      r_num;
    logic [csi_pkg::DIV_DW-1:0]      r_den;
    logic                            r_neg;

    logic                 r_out_valid;
    logic signed [PW-1:0] r_pos [3];
    logic                 r_moving;

    // sequencer outputs
    logic in_ready;
    logic div_start;
    logic out_load;

    logic                          accept;
    logic                          div_done;
    logic [csi_pkg::DIV_NW-1:0]    div_quo;

    // datapath helpers
    logic signed [2*DW-1:0]          sq;
    logic [csi_pkg::ROOT_W+2:0]      rt_sh;
    logic [csi_pkg::ROOT_W+2:0]      rt_trial;
    logic                            rt_ge;
    logic [csi_pkg::TIME_W:0]        e_sum;
    logic [csi_pkg::TIME_W-1:0]      e_new;
    logic [DW-1:0]                   dmag;
    logic [csi_pkg::SPEED_W-1:0]     spd_eff;
    logic signed [DW:0]              q_s;
    logic signed [DW+1:0]            p_sum;
    logic signed [PW-1:0]            p_clamp;
    logic signed [PW-1:0]            tgt [3];

    assign accept = i_item.valid && in_ready;
    assign tgt[0] = i_item.target_x;
    assign tgt[1] = i_item.target_y;
    assign tgt[2] = i_item.target_z;

    csi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            csi_pkg::ST_IDLE:  if (accept) begin
                n_state = (i_item.kind == csi_pkg::KIND_TARGET) ? csi_pkg::ST_SQ
                                                                : csi_pkg::ST_TSTEP;
            end
            csi_pkg::ST_SQ:    if (r_ax == 2'd2) n_state = csi_pkg::ST_ROOT;
            csi_pkg::ST_ROOT:  if (r_cnt == csi_pkg::ROOT_CNT_W'(csi_pkg::ROOT_W - 1))
                                   n_state = csi_pkg::ST_SCALE;
            csi_pkg::ST_SCALE: n_state = (r_root == '0) ? csi_pkg::ST_OUT : csi_pkg::ST_DGO;
            csi_pkg::ST_DGO:   n_state = csi_pkg::ST_DDIV;
            csi_pkg::ST_DDIV:  if (div_done) n_state = csi_pkg::ST_OUT;
            csi_pkg::ST_TSTEP: n_state = (r_elapsed < r_dur) ? csi_pkg::ST_TMUL
                                                             : csi_pkg::ST_OUT;
            csi_pkg::ST_TMUL:  n_state = csi_pkg::ST_TGO;
            csi_pkg::ST_TGO:   n_state = csi_pkg::ST_TDIV;
            csi_pkg::ST_TDIV:  if (div_done) begin
                n_state = (r_ax == 2'd2) ? csi_pkg::ST_OUT : csi_pkg::ST_TMUL;
            end
            csi_pkg::ST_OUT:   if (!r_out_valid || o_result.ready) n_state = csi_pkg::ST_IDLE;
            default:           n_state = csi_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            csi_pkg::ST_IDLE: in_ready  = 1'b1;
            csi_pkg::ST_DGO,
            csi_pkg::ST_TGO:  div_start = 1'b1;
            csi_pkg::ST_OUT:  out_load  = !r_out_valid || o_result.ready;
            default: begin
                in_ready  = 1'b0;
                div_start = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    always_comb begin
        sq       = r_delta[r_ax] * r_delta[r_ax];
        rt_sh    = {r_rem, r_acc[csi_pkg::SQ_W-1 -: 2]};
        rt_trial = {1'b0, r_root, 2'b01};
        rt_ge    = rt_sh >= rt_trial;
        e_sum    = {1'b0, r_elapsed} + (csi_pkg::TIME_W + 1)'(r_step);
        e_new    = (e_sum > {1'b0, r_dur}) ? r_dur : e_sum[csi_pkg::TIME_W-1:0];
        dmag     = r_delta[r_ax][DW-1] ? DW'(-r_delta[r_ax]) : DW'(r_delta[r_ax]);
        spd_eff  = (r_speed == '0) ? csi_pkg::SPEED_W'(1) : r_speed;
        // quotient never exceeds |delta|
        q_s      = r_neg ? -$signed({1'b0, div_quo[DW-1:0]}) : $signed({1'b0, div_quo[DW-1:0]});
        p_sum    = (DW + 2)'(r_start[r_ax]) + (DW + 2)'(q_s);
        if (p_sum > (DW + 2)'(32767))       p_clamp = 16'sh7FFF;
        else if (p_sum < -(DW + 2)'(32768)) p_clamp = 16'sh8000;
        else                                p_clamp = p_sum[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csi_pkg::ST_IDLE;
            r_speed     <= csi_pkg::MOVE_SPEED_RST;
            r_step      <= csi_pkg::TICK_STEP_RST;
            r_elapsed   <= '0;
            r_dur       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cur[i]   <= '0;
                r_start[i] <= '0;
                r_delta[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                if (i_cfg.index == csi_pkg::CFG_MOVE_SPEED)
                    r_speed <= i_cfg.data[csi_pkg::SPEED_W-1:0];
                else if (i_cfg.index == csi_pkg::CFG_TICK_STEP_US)
                    r_step <= i_cfg.data;
            end

            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_result.ready)
                r_out_valid <= 1'b0;

            case (r_state)
                csi_pkg::ST_IDLE: if (accept) begin
                    r_ax <= 2'd0;
                    if (i_item.kind == csi_pkg::KIND_TARGET) begin
                        for (int i = 0; i < 3; i++) begin
                            r_start[i] <= r_cur[i];
                            r_delta[i] <= DW'(tgt[i]) - DW'(r_cur[i]);
                        end
                        r_elapsed <= '0;
                        r_acc     <= '0;
                        r_root    <= '0;
                        r_rem     <= '0;
                        r_cnt     <= '0;
                    end
                end
                csi_pkg::ST_SQ: begin
                    r_acc <= r_acc + csi_pkg::SQ_W'(unsigned'(sq));
                    r_ax  <= r_ax + 2'd1;
                end
                csi_pkg::ST_ROOT: begin
                    // one base-4 digit of the radicand per cycle, giving one root bit
                    r_acc  <= {r_acc[csi_pkg::SQ_W-3:0], 2'b00};
                    r_rem  <= rt_ge ? (csi_pkg::ROOT_W + 1)'(rt_sh - rt_trial)
                                    : (csi_pkg::ROOT_W + 1)'(rt_sh);
                    r_root <= {r_root[csi_pkg::ROOT_W-2:0], rt_ge};
                    r_cnt  <= r_cnt + 1'b1;
                end
                csi_pkg::ST_SCALE: begin
                    if (r_root == '0) r_dur <= '0;
                    r_num <= csi_pkg::DIV_NW'(r_root * csi_pkg::US_SCALE);
                    r_den <= csi_pkg::DIV_DW'(spd_eff) << csi_pkg::POS_FRAC_BITS;
                end
                csi_pkg::ST_DDIV: if (div_done) begin
                    if (|div_quo[csi_pkg::DIV_NW-1:csi_pkg::TIME_W])
                        r_dur <= '1;
                    else if (div_quo[csi_pkg::TIME_W-1:0] == '0)
                        r_dur <= csi_pkg::TIME_W'(1);
                    else
                        r_dur <= div_quo[csi_pkg::TIME_W-1:0];
                end
                csi_pkg::ST_TSTEP: begin
                    if (r_elapsed < r_dur) r_elapsed <= e_new;
                    r_ax <= 2'd0;
                end
                csi_pkg::ST_TMUL: begin
                    r_num <= csi_pkg::DIV_NW'(dmag * r_elapsed);
                    r_neg <= r_delta[r_ax][DW-1];
                    r_den <= csi_pkg::DIV_DW'(r_dur);
                end
                csi_pkg::ST_TDIV: if (div_done) begin
                    r_cur[r_ax] <= p_clamp;
                    r_ax        <= r_ax + 2'd1;
                end
                csi_pkg::ST_OUT: if (out_load) begin
                    for (int i = 0; i < 3; i++) r_pos[i] <= r_cur[i];
                    r_moving <= r_elapsed < r_dur;
                end
                default: r_ax <= r_ax;
            endcase
        end
    end

    assign i_item.ready    = in_ready;
    assign i_cfg.ready     = 1'b1;
    assign o_result.valid  = r_out_valid;
    assign o_result.pos_x  = r_pos[0];
    assign o_result.pos_y  = r_pos[1];
    assign o_result.pos_z  = r_pos[2];
    assign o_result.moving = r_moving;
endmodule

// File: verif/csi_tb_channels.sv
// Testbench-side copy is not needed; interfaces come from the RTL channel file.
// Holds a small shared result type for the interpolator testbench.
// Depends on csi_pkg.
package csi_tb_pkg;
    typedef struct packed {
        logic signed [csi_pkg::POS_W-1:0] pos_x;
        logic signed [csi_pkg::POS_W-1:0] pos_y;
        logic signed [csi_pkg::POS_W-1:0] pos_z;
        logic                             moving;
    } t_pos_result;
endpackage

// File: verif/constant_speed_setpoint_interpolator_top_tb.sv
// Testbench for the constant-speed setpoint interpolator: random target/tick items,
// config changes between phases, results checked against an in-bench position predictor.
// Depends on csi_pkg, csi_tb_pkg, csi_channels and the RTL top.
module constant_speed_setpoint_interpolator_top_tb;

    class position_scoreboard;
        logic [15:0] speed;
        logic [19:0] step;
        int signed   cur[3];
        int signed   start_p[3];
        int signed   delta[3];
        longint unsigned elapsed;
        longint unsigned duration;
        csi_tb_pkg::t_pos_result expected_q[$];
        int errors;

        function void clear();
            speed = csi_pkg::MOVE_SPEED_RST;
            step = csi_pkg::TICK_STEP_RST;
            for (int i = 0; i < 3; i++) begin
                cur[i] = 0; start_p[i] = 0; delta[i] = 0;
            end
            elapsed = 0;
            duration = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [csi_pkg::CFG_IDX_W-1:0] idx,
                                logic [csi_pkg::CFG_DATA_W-1:0] val);
            if (idx == csi_pkg::CFG_MOVE_SPEED) speed = val[15:0];
            else if (idx == csi_pkg::CFG_TICK_STEP_US) step = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            r = 0;
            for (int b = 20; b >= 0; b--)
                if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r += 64'd1 << b;
            return r;
        endfunction

        function void note_item(logic kind, logic signed [15:0] tx, logic signed [15:0] ty,
                                logic signed [15:0] tz);
            int signed t[3];
            longint unsigned sumsq, num, den, dur, spd;
            longint signed prod, q, p;
            csi_tb_pkg::t_pos_result r;
            t[0] = tx; t[1] = ty; t[2] = tz;
            if (kind == csi_pkg::KIND_TARGET) begin
                sumsq = 0;
                for (int i = 0; i < 3; i++) begin
                    start_p[i] = cur[i];
                    delta[i] = t[i] - cur[i];
                    sumsq += longint'(delta[i]) * longint'(delta[i]);
                end
                elapsed = 0;
                if (sumsq == 0) duration = 0;
                else begin
                    spd = (speed == 0) ? 64'd1 : 64'(speed);
                    num = int_sqrt(sumsq) * 256 * 1000000;
                    den = spd << csi_pkg::POS_FRAC_BITS;
                    dur = num / den;
                    if (dur > 64'hFFFF_FFFF) dur = 64'hFFFF_FFFF;
                    if (dur == 0) dur = 1;
                    duration = dur;
                end
            end else if (elapsed < duration) begin
                elapsed = elapsed + step;
                if (elapsed > duration) elapsed = duration;
                for (int i = 0; i < 3; i++) begin
                    prod = longint'(delta[i]) * longint'(elapsed);
                    q = prod / longint'(duration);
                    p = longint'(start_p[i]) + q;
                    cur[i] = (p > 32767) ? 32767 : (p < -32768) ? -32768 : int'(p);
                end
            end
            r.pos_x = 16'(cur[0]); r.pos_y = 16'(cur[1]); r.pos_z = 16'(cur[2]);
            r.moving = elapsed < duration;
            expected_q.push_back(r);
        endfunction

        function void check_result(csi_tb_pkg::t_pos_result act);
            csi_tb_pkg::t_pos_result e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %p", act);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (act.pos_x !== e.pos_x) begin
                $error("pos_x expected %0d got %0d", e.pos_x, act.pos_x); errors++;
            end
            if (act.pos_y !== e.pos_y) begin
                $error("pos_y expected %0d got %0d", e.pos_y, act.pos_y); errors++;
            end
            if (act.pos_z !== e.pos_z) begin
                $error("pos_z expected %0d got %0d", e.pos_z, act.pos_z); errors++;
            end
            if (act.moving !== e.moving) begin
                $error("moving expected %0b got %0b", e.moving, act.moving); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    csi_item_if   item_ch();
    csi_result_if result_ch();
    csi_cfg_if    cfg_ch();
    position_scoreboard sb;
    bit stim_done = 1'b0;

    always #6 i_clk = ~i_clk;

    constant_speed_setpoint_interpolator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch.sink), .o_result(result_ch.source), .i_cfg(cfg_ch.sink)
    );

    initial begin
        item_ch.valid = 1'b0; item_ch.kind = 1'b0;
        item_ch.target_x = '0; item_ch.target_y = '0; item_ch.target_z = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    end

    // result sink: random stalls, sometimes none
    initial begin : result_sink
        int gap;
        csi_tb_pkg::t_pos_result act;
        wait (i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            act.pos_x = result_ch.pos_x; act.pos_y = result_ch.pos_y;
            act.pos_z = result_ch.pos_z; act.moving = result_ch.moving;
            sb.check_result(act);
        end
    end

    // valid stays up after an accepted item until the next gap or a drain
    task automatic send_item(logic kind, logic signed [15:0] tx, logic signed [15:0] ty,
                             logic signed [15:0] tz, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1; item_ch.kind <= kind;
        item_ch.target_x <= tx; item_ch.target_y <= ty; item_ch.target_z <= tz;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_item(kind, tx, ty, tz);
    endtask

    task automatic write_reg(logic [csi_pkg::CFG_IDX_W-1:0] idx,
                             logic [csi_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(csi_pkg::KIND_TARGET, rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 3) == 0);
            else
                send_item(~csi_pkg::KIND_TARGET, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin : stimulus
        sb = new();
        sb.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, zero-length move, extremes, short move, retarget mid-move
        send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 1);
        send_item(csi_pkg::KIND_TARGET, '0, '0, '0, 1);
        send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 0);
        send_item(csi_pkg::KIND_TARGET, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        repeat (3) send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 0);
        send_item(csi_pkg::KIND_TARGET, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        repeat (3) send_item(~csi_pkg::KIND_TARGET, 16'shFFFF, 16'shFFFF, 16'shFFFF, 0);
        drain();
        write_reg(csi_pkg::CFG_MOVE_SPEED, 20'hFFFFF);
        write_reg(csi_pkg::CFG_TICK_STEP_US, 20'hFFFFF);
        send_item(csi_pkg::KIND_TARGET, 16'sh0001, 16'sh0000, 16'sh0000, 0);
        send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 0);
        send_item(csi_pkg::KIND_TARGET, 16'sh7FFF, 16'sh8000, 16'sh0000, 0);
        repeat (2) send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 0);
        drain();
        write_reg(csi_pkg::CFG_MOVE_SPEED, '0);
        write_reg(csi_pkg::CFG_TICK_STEP_US, '0);
        write_reg(8'd7, 20'h12345);
        send_item(csi_pkg::KIND_TARGET, 16'sh1000, 16'shF000, 16'sh0800, 0);
        repeat (2) send_item(~csi_pkg::KIND_TARGET, '0, '0, '0, 0);
        drain();

        // random phases under several settings
        write_reg(csi_pkg::CFG_MOVE_SPEED, 20'd256);
        write_reg(csi_pkg::CFG_TICK_STEP_US, 20'd10000);
        random_phase(140);
        drain();
        write_reg(csi_pkg::CFG_MOVE_SPEED, 20'hFFFF);
        write_reg(csi_pkg::CFG_TICK_STEP_US, 20'd1);
        random_phase(70);
        drain();
        write_reg(csi_pkg::CFG_MOVE_SPEED, 20'd1);
        write_reg(csi_pkg::CFG_TICK_STEP_US, 20'hFFFFF);
        random_phase(70);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_reg(csi_pkg::CFG_MOVE_SPEED, 20'($urandom_range(1, 65535)));
            write_reg(csi_pkg::CFG_TICK_STEP_US, 20'($urandom_range(1000, 1048575)));
            random_phase(65);
            drain();
        end
        stim_done = 1'b1;
    end

    initial begin : finish_check
        wait (stim_done);
        if (sb.errors == 0)
            $display("** constant_speed_setpoint_interpolator_top: PASSED **");
        else
            $display("** constant_speed_setpoint_interpolator_top: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #6000000;
        $display("** constant_speed_setpoint_interpolator_top: FAILED **");
        $finish;
    end
endmodule
